@@ design/gis_pkg.sv @@
// gis_pkg: shared types and constants for the greedy independent set stream
// used by gis_front, gis_back and greedy_independent_set_stream

package gis_pkg;

    localparam int NODE_W      = 10;
    localparam int CNT_W       = 11;
    localparam int GEN_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [1:0] MARK_UNVISITED = 2'd0;
    localparam logic [1:0] MARK_SELECTED  = 2'd1;
    localparam logic [1:0] MARK_EXCLUDED  = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [GEN_W-1:0] GEN_MAX   = '1;

    // one classified adjacency entry on its way from front to back
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] neighbor;
        logic              node_ok;
        logic              nb_ok;
        logic              last;
        logic              fresh;
    } entry_t;

    // mark store word: generation tag plus node mark
    typedef struct packed {
        logic [GEN_W-1:0] tag;
        logic [1:0]       mark;
    } mark_entry_t;

endpackage

@@ design/gis_front.sv @@
// gis_front: accepts input beats, classifies each entry, queues it for the back end
// depends on gis_pkg

module gis_front import gis_pkg::*; #(
    parameter int NODES = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [NODE_W-1:0] s_node,
    input  logic [NODE_W-1:0] s_neighbor,
    input  logic              s_has_neighbor,
    input  logic              s_last_of_row,
    input  logic              s_new_graph,
    output logic              q_valid,
    output entry_t            q_entry,
    input  logic              q_ready
);

    localparam logic [16:0] NODES_V = 17'(NODES);
    localparam logic [QUEUE_AW:0] FULL_CNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    entry_t               in_entry;
    entry_t               queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]    cnt_reg, cnt_next;
    logic                 push, pop;

    always_comb begin
        in_entry.node     = s_node;
        in_entry.neighbor = s_neighbor;
        in_entry.node_ok  = ({7'd0, s_node} < NODES_V);
        in_entry.nb_ok    = s_has_neighbor && (s_neighbor != s_node)
                            && ({7'd0, s_neighbor} < NODES_V);
        in_entry.last     = s_last_of_row;
        in_entry.fresh    = s_new_graph;
    end

    assign s_ready = (cnt_reg != FULL_CNT);
    assign q_valid = (cnt_reg != '0);
    assign q_entry = queue_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

@@ design/gis_back.sv @@
// gis_back: row sequencer with mark store, neighbor buffer and result register
// depends on gis_pkg; fed by gis_front

module gis_back import gis_pkg::*; #(
    parameter int NODES      = 1024,
    parameter int MAX_DEGREE = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  entry_t            q_entry,
    output logic              q_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [NODE_W-1:0] m_decided_node,
    output logic              m_selected,
    output logic [CNT_W-1:0]  m_set_size,
    output logic              m_row_overflow
);

    localparam int AW     = $clog2(NODES);
    localparam int FILL_W = $clog2(MAX_DEGREE + 1);
    localparam int BUF_AW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_DEGREE);
    localparam logic [AW-1:0]     CLR_LAST = AW'(NODES - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_ISSUE  = 3'd1;
    localparam logic [2:0] ST_EVAL   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [GEN_W-1:0]  gen_reg, gen_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    entry_t            cur_reg, cur_next;
    logic              in_row_reg, in_row_next;
    logic              first_reg, first_next;
    logic              open_reg, open_next;
    logic              blocked_reg, blocked_next;
    logic              ovf_reg, ovf_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] walk_reg, walk_next;
    logic [FILL_W-1:0] walk_inc;
    logic              chosen_reg, chosen_next;
    logic              m_valid_reg, m_valid_next;
    logic [NODE_W-1:0] res_node_reg;
    logic              res_sel_reg;
    logic [CNT_W-1:0]  res_size_reg;
    logic              res_ovf_reg;

    mark_entry_t       mark_mem [NODES];
    mark_entry_t       rd_a_q, rd_b_q;
    logic [NODE_W-1:0] row_buf [MAX_DEGREE];
    logic [NODE_W-1:0] buf_q;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    mark_entry_t       mem_wdata;
    logic              rd_en;
    logic [AW-1:0]     rd_a_addr, rd_b_addr;
    logic              buf_we;
    logic [BUF_AW-1:0] buf_waddr;
    logic              buf_re;
    logic [BUF_AW-1:0] buf_raddr;
    logic              out_load;
    logic              row_start;
    logic [1:0]        eff_a, eff_b;

    // stale generation tag reads as unvisited
    assign eff_a    = (rd_a_q.tag == gen_reg) ? rd_a_q.mark : MARK_UNVISITED;
    assign eff_b    = (rd_b_q.tag == gen_reg) ? rd_b_q.mark : MARK_UNVISITED;
    assign walk_inc = walk_reg + 1'b1;
    assign row_start = q_entry.fresh || !in_row_reg;

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        gen_next     = gen_reg;
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        in_row_next  = in_row_reg;
        first_next   = first_reg;
        open_next    = open_reg;
        blocked_next = blocked_reg;
        ovf_next     = ovf_reg;
        fill_next    = fill_reg;
        walk_next    = walk_reg;
        chosen_next  = chosen_reg;
        mem_we       = 1'b0;
        mem_waddr    = clr_reg;
        mem_wdata    = '{tag: gen_reg, mark: MARK_UNVISITED};
        rd_en        = 1'b0;
        rd_a_addr    = AW'(q_entry.node);
        rd_b_addr    = AW'(q_entry.neighbor);
        buf_we       = 1'b0;
        buf_waddr    = fill_reg[BUF_AW-1:0];
        buf_re       = 1'b0;
        buf_raddr    = '0;
        q_ready      = 1'b0;
        out_load     = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '{tag: '0, mark: MARK_UNVISITED};
                if (clr_reg == CLR_LAST) begin
                    gen_next   = '0;
                    state_next = ST_ISSUE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_ISSUE: begin
                if (q_valid) begin
                    if (q_entry.fresh && (gen_reg == GEN_MAX)) begin
                        // tag space used up: sweep the store first
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end else begin
                        q_ready     = 1'b1;
                        rd_en       = 1'b1;
                        cur_next    = q_entry;
                        first_next  = row_start;
                        in_row_next = 1'b1;
                        state_next  = ST_EVAL;
                        if (q_entry.fresh) begin
                            gen_next = gen_reg + 1'b1;
                            cnt_next = '0;
                        end
                        if (row_start) begin
                            fill_next    = '0;
                            blocked_next = 1'b0;
                            ovf_next     = 1'b0;
                        end
                    end
                end
            end
            ST_EVAL: begin
                if (first_reg) begin
                    open_next = cur_reg.node_ok && (eff_a == MARK_UNVISITED);
                end
                if (cur_reg.nb_ok) begin
                    if (eff_b == MARK_SELECTED) begin
                        blocked_next = 1'b1;
                    end
                    if (fill_reg < FILL_MAX) begin
                        buf_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                state_next = cur_reg.last ? ST_DECIDE : ST_ISSUE;
            end
            ST_DECIDE: begin
                in_row_next = 1'b0;
                chosen_next = 1'b0;
                state_next  = ST_DONE;
                mem_waddr   = AW'(cur_reg.node);
                if (open_reg && cur_reg.node_ok) begin
                    mem_we = 1'b1;
                    if (!blocked_reg) begin
                        mem_wdata   = '{tag: gen_reg, mark: MARK_SELECTED};
                        chosen_next = 1'b1;
                        if (cnt_reg != COUNT_MAX) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        if (fill_reg != '0) begin
                            buf_re     = 1'b1;
                            walk_next  = '0;
                            state_next = ST_WALK;
                        end
                    end else begin
                        mem_wdata = '{tag: gen_reg, mark: MARK_EXCLUDED};
                    end
                end
            end
            ST_WALK: begin
                mem_we    = (buf_q != cur_reg.node);
                mem_waddr = AW'(buf_q);
                mem_wdata = '{tag: gen_reg, mark: MARK_EXCLUDED};
                if (walk_inc == fill_reg) begin
                    state_next = ST_DONE;
                end else begin
                    buf_re    = 1'b1;
                    buf_raddr = walk_inc[BUF_AW-1:0];
                    walk_next = walk_inc;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            gen_reg     <= '0;
            cnt_reg     <= '0;
            in_row_reg  <= 1'b0;
            first_reg   <= 1'b0;
            open_reg    <= 1'b0;
            blocked_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            fill_reg    <= '0;
            walk_reg    <= '0;
            chosen_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            gen_reg     <= gen_next;
            cnt_reg     <= cnt_next;
            in_row_reg  <= in_row_next;
            first_reg   <= first_next;
            open_reg    <= open_next;
            blocked_reg <= blocked_next;
            ovf_reg     <= ovf_next;
            fill_reg    <= fill_next;
            walk_reg    <= walk_next;
            chosen_reg  <= chosen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (out_load) begin
            res_node_reg <= cur_reg.node;
            res_sel_reg  <= chosen_reg;
            res_size_reg <= cnt_reg;
            res_ovf_reg  <= ovf_reg;
        end
    end

    // mark store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mark_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_q <= mark_mem[rd_a_addr];
            rd_b_q <= mark_mem[rd_b_addr];
        end
    end

    // neighbor buffer of the open row
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            row_buf[buf_waddr] <= cur_reg.neighbor;
        end
        if (buf_re) begin
            buf_q <= row_buf[buf_raddr];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_decided_node = res_node_reg;
    assign m_selected     = res_sel_reg;
    assign m_set_size     = res_size_reg;
    assign m_row_overflow = res_ovf_reg;

`ifndef NO_ASSERTIONS
    a_no_write_on_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE) |-> !mem_we)
        else $error("mark store written during lookup issue");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("neighbor buffer fill beyond depth");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (walk_reg < fill_reg))
        else $error("walk index past buffer fill");

    a_tag_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready && q_entry.fresh) |-> (gen_reg != GEN_MAX))
        else $error("new graph taken with generation tags exhausted");

    a_selected_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_selected) |-> (m_set_size != '0))
        else $error("selected node reported with empty set");
`endif

endmodule

@@ design/greedy_independent_set_stream.sv @@
// greedy_independent_set_stream: top level of the streaming greedy independent set
// depends on gis_pkg, gis_front, gis_back
//
//   channel | ports | beat carries
//   --------+-------+----------------------------------------------------------------
//   input   | s_*   | node, neighbor, has_neighbor, last_of_row, new_graph
//   result  | m_*   | decided_node, selected, set_size, row_overflow (one per row end)
//
// in the back end each adjacency beat goes through lookup issue, then mark evaluation
// a row end adds the decide and done steps, plus a walk over the buffered neighbors when the node is selected
// after reset every entry of the mark store is swept before the first beat is processed;
// the same sweep runs on the new-graph beat that follows seven earlier new-graph beats
// a 4-entry queue keeps input beats flowing while the back end walks or the result stalls

module greedy_independent_set_stream import gis_pkg::*; #(
    parameter int NODES      = 1024,
    parameter int MAX_DEGREE = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [NODE_W-1:0] s_node,
    input  logic [NODE_W-1:0] s_neighbor,
    input  logic              s_has_neighbor,
    input  logic              s_last_of_row,
    input  logic              s_new_graph,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [NODE_W-1:0] m_decided_node,
    output logic              m_selected,
    output logic [CNT_W-1:0]  m_set_size,
    output logic              m_row_overflow
);

    logic   q_valid;
    logic   q_ready;
    entry_t q_entry;

    gis_front #(
        .NODES (NODES)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_node         (s_node),
        .s_neighbor     (s_neighbor),
        .s_has_neighbor (s_has_neighbor),
        .s_last_of_row  (s_last_of_row),
        .s_new_graph    (s_new_graph),
        .q_valid        (q_valid),
        .q_entry        (q_entry),
        .q_ready        (q_ready)
    );

    gis_back #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_entry        (q_entry),
        .q_ready        (q_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_decided_node (m_decided_node),
        .m_selected     (m_selected),
        .m_set_size     (m_set_size),
        .m_row_overflow (m_row_overflow)
    );

endmodule

@@ test/greedy_independent_set_stream_tb.sv @@
// greedy_independent_set_stream_tb: checks the streaming greedy independent set block
// a scoreboard class tracks node marks and the set count per graph and checks each row result
// depends on gis_pkg and greedy_independent_set_stream

module greedy_independent_set_stream_tb import gis_pkg::*;;

    localparam int NODES      = 1024;
    localparam int MAX_DEGREE = 64;

    typedef struct {
        logic [NODE_W-1:0] node;
        logic              selected;
        logic [CNT_W-1:0]  set_size;
        logic              row_overflow;
    } decision_t;

    class mis_scoreboard;
        logic [1:0]        marks [NODES];
        logic [NODE_W-1:0] row_nbrs [MAX_DEGREE];
        int unsigned       fill;
        bit                row_is_open;
        bit                row_is_blocked;
        bit                row_active;
        bit                row_ovf;
        logic [CNT_W-1:0]  set_count;
        decision_t         decisions_due [$];
        int                mismatches;

        function new();
            foreach (marks[i]) marks[i] = MARK_UNVISITED;
            set_count  = '0;
            mismatches = 0;
            clear_row();
        endfunction

        function void clear_row();
            fill           = 0;
            row_is_open    = 0;
            row_is_blocked = 0;
            row_active     = 0;
            row_ovf        = 0;
        endfunction

        function void note_beat(logic [NODE_W-1:0] nd, logic [NODE_W-1:0] nb,
                                logic hn, logic lr, logic ng);
            decision_t d;
            bit        node_ok;
            node_ok = nd < NODES;
            if (ng) begin
                foreach (marks[i]) marks[i] = MARK_UNVISITED;
                set_count = '0;
                clear_row();
            end
            if (!row_active) begin
                row_active     = 1;
                fill           = 0;
                row_is_blocked = 0;
                row_ovf        = 0;
                row_is_open    = node_ok && marks[nd] == MARK_UNVISITED;
            end
            if (hn && nb != nd && nb < NODES) begin
                if (marks[nb] == MARK_SELECTED) row_is_blocked = 1;
                if (fill < MAX_DEGREE) begin
                    row_nbrs[fill] = nb;
                    fill++;
                end else begin
                    row_ovf = 1;
                end
            end
            if (!lr) return;
            d.selected = 1'b0;
            if (row_is_open && node_ok) begin
                if (!row_is_blocked) begin
                    d.selected = 1'b1;
                    marks[nd]  = MARK_SELECTED;
                    if (set_count != COUNT_MAX) set_count++;
                    for (int k = 0; k < fill; k++) begin
                        if (row_nbrs[k] != nd) marks[row_nbrs[k]] = MARK_EXCLUDED;
                    end
                end else begin
                    marks[nd] = MARK_EXCLUDED;
                end
            end
            d.node         = nd;
            d.set_size     = set_count;
            d.row_overflow = row_ovf;
            decisions_due.push_back(d);
            clear_row();
        endfunction

        function void check_decision(logic [NODE_W-1:0] nd, logic sel,
                                     logic [CNT_W-1:0] size, logic ovf);
            decision_t d;
            if (decisions_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: node %0d selected %0b size %0d ovf %0b",
                             nd, sel, size, ovf);
                return;
            end
            d = decisions_due.pop_front();
            if (nd !== d.node || sel !== d.selected || size !== d.set_size
                    || ovf !== d.row_overflow) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d %0b %0d %0b, got %0d %0b %0d %0b",
                             d.node, d.selected, d.set_size, d.row_overflow,
                             nd, sel, size, ovf);
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [NODE_W-1:0] s_node         = '0;
    logic [NODE_W-1:0] s_neighbor     = '0;
    logic              s_has_neighbor = 1'b0;
    logic              s_last_of_row  = 1'b0;
    logic              s_new_graph    = 1'b0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [NODE_W-1:0] m_decided_node;
    logic              m_selected;
    logic [CNT_W-1:0]  m_set_size;
    logic              m_row_overflow;

    int            send_idle  = 0;
    int            recv_stall = 0;
    mis_scoreboard sb         = new();

    greedy_independent_set_stream #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_node         (s_node),
        .s_neighbor     (s_neighbor),
        .s_has_neighbor (s_has_neighbor),
        .s_last_of_row  (s_last_of_row),
        .s_new_graph    (s_new_graph),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_decided_node (m_decided_node),
        .m_selected     (m_selected),
        .m_set_size     (m_set_size),
        .m_row_overflow (m_row_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_decision(m_decided_node, m_selected, m_set_size, m_row_overflow);
    end

    task automatic send_beat(logic [NODE_W-1:0] nd, logic [NODE_W-1:0] nb,
                             logic hn, logic lr, logic ng);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_node         <= nd;
        s_neighbor     <= nb;
        s_has_neighbor <= hn;
        s_last_of_row  <= lr;
        s_new_graph    <= ng;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(nd, nb, hn, lr, ng);
    endtask

    task automatic run_directed();
        // empty row selects, blocked row, revisits, self entry
        send_beat(10'd0,    10'd1023, 1'b0, 1'b1, 1'b1);
        send_beat(10'd1023, 10'd0,    1'b1, 1'b1, 1'b0);
        send_beat(10'd1023, 10'd5,    1'b1, 1'b1, 1'b0);
        send_beat(10'd5,    10'd5,    1'b1, 1'b1, 1'b0);
        send_beat(10'd0,    10'd1023, 1'b1, 1'b1, 1'b0);
        send_beat(10'd10,   10'd11,   1'b1, 1'b0, 1'b0);
        send_beat(10'd10,   10'd12,   1'b1, 1'b0, 1'b0);
        send_beat(10'd10,   10'd10,   1'b1, 1'b1, 1'b0);
        send_beat(10'd11,   10'd20,   1'b1, 1'b1, 1'b0);
        // node changes inside a row
        send_beat(10'd30,   10'd31,   1'b1, 1'b0, 1'b0);
        send_beat(10'd10,   10'd50,   1'b1, 1'b1, 1'b0);
        // new graph abandons an open row
        send_beat(10'd100,  10'd101,  1'b1, 1'b0, 1'b0);
        send_beat(10'd101,  10'd100,  1'b1, 1'b1, 1'b1);
        send_beat(10'd100,  10'd101,  1'b1, 1'b1, 1'b0);
        send_beat(10'd200,  10'd0,    1'b0, 1'b0, 1'b0);
        send_beat(10'd200,  10'd1023, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic run_random(int n_items);
        int                sent;
        int                span;
        int                rows;
        int                len;
        int                roll;
        bit                first;
        logic [NODE_W-1:0] base;
        logic [NODE_W-1:0] nd;
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] nb;
        logic              hn;
        logic              ng;
        sent = 0;
        while (sent < n_items) begin
            base  = NODE_W'($urandom_range(0, 1023));
            span  = $urandom_range(4, 48);
            rows  = $urandom_range(3, 25);
            first = 1;
            for (int r = 0; r < rows && sent < n_items; r++) begin
                nd   = base + NODE_W'($urandom_range(0, span - 1));
                roll = $urandom_range(0, 99);
                if (roll < 2)       len = $urandom_range(64, 90);
                else if (roll < 10) len = 1;
                else                len = $urandom_range(1, 6);
                for (int e = 0; e < len; e++) begin
                    roll = $urandom_range(0, 99);
                    hn   = (roll >= 5);
                    if (roll < 10)      nb = nd;
                    else if (roll < 15) nb = NODE_W'($urandom_range(0, 1023));
                    else                nb = base + NODE_W'($urandom_range(0, span - 1));
                    cur = nd;
                    if (e > 0 && $urandom_range(0, 99) < 2)
                        cur = NODE_W'($urandom_range(0, 1023));
                    ng    = first || ($urandom_range(0, 199) == 0);
                    first = 0;
                    send_beat(cur, nb, hn, e == len - 1, ng);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random(300);
        send_idle  = 56;
        run_random(300);
        send_idle  = 0;
        recv_stall = 56;
        run_random(300);
        send_idle  = 10;
        recv_stall = 10;
        run_random(300);
        s_valid <= 1'b0;
        while (sb.decisions_due.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.mismatches == 0 && sb.decisions_due.size() == 0)
            $display("greedy_independent_set_stream test passed");
        else
            $display("greedy_independent_set_stream test failed");
        $finish;
    end

    initial begin
        #5000000;
        $display("greedy_independent_set_stream test failed");
        $finish;
    end

endmodule

@@ files.f @@
design/gis_pkg.sv
design/gis_front.sv
design/gis_back.sv
design/greedy_independent_set_stream.sv
test/greedy_independent_set_stream_tb.sv
